FILE: rtl/udp_lci_pkg.sv
// ----------------------------------------------------------------------------
// udp_lci_pkg
// shared types and constants for the udp length and checksum filler
// ----------------------------------------------------------------------------
package udp_lci_pkg;

    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FILL_LENGTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_CHECKSUM = 1'b1;

    localparam logic        MODE_START = 1'b0;
    localparam logic        MODE_WORD  = 1'b1;
    localparam logic [1:0]  BV_ONE     = 2'd1;

    localparam logic [15:0] LEN_WORD_OFFSET  = 16'd4;
    localparam logic [15:0] CSUM_WORD_OFFSET = 16'd6;
    localparam logic [15:0] IP_HEADER_BYTES  = 16'd20;
    localparam logic [15:0] ALL_ONES         = 16'hffff;

    typedef struct packed {
        logic        mode;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  proto_num;
        logic [15:0] ip_total_len;
        logic [15:0] data_word;
        logic [1:0]  byte_valid;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [15:0] udp_length;
        logic [15:0] udp_checksum;
    } out_item_t;

    typedef struct packed {
        logic fill_length;
        logic fill_checksum;
    } cfg_t;

endpackage

FILE: rtl/udp_lci_cfg.sv
// ----------------------------------------------------------------------------
// udp_lci_cfg
// configuration registers, written through a valid/ready port
// ----------------------------------------------------------------------------
module udp_lci_cfg
    import udp_lci_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FILL_LENGTH:   cfg_next.fill_length   = cfg_data;
                REG_FILL_CHECKSUM: cfg_next.fill_checksum = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fill_length   <= 1'b1;
            cfg_reg.fill_checksum <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/udp_lci_core.sv
// ----------------------------------------------------------------------------
// udp_lci_core
// running ones-complement sum and byte count, result for the last word
// ----------------------------------------------------------------------------
module udp_lci_core
    import udp_lci_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic [15:0] sum_reg,   sum_next;
    logic [15:0] count_reg, count_next;

    logic [18:0] seed_wide;
    logic [15:0] seed_sum;
    logic [15:0] word_masked;
    logic [1:0]  nbytes;
    logic [15:0] addend;
    logic [16:0] count_wide;
    logic [15:0] count_sat;
    logic [15:0] len_term;
    logic [18:0] total_wide;
    logic [15:0] total_sum;
    logic [15:0] csum_inv;

    // two end-around folds bring any sum of up to eight words into 16 bits
    function automatic logic [15:0] fold(input logic [18:0] s);
        logic [16:0] f1;
        logic [16:0] f2;
        f1 = {1'b0, s[15:0]} + {14'd0, s[18:16]};
        f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
        return f2[15:0];
    endfunction

    always_comb
    begin
        seed_wide = {3'd0, item.src_addr[31:16]} + {3'd0, item.src_addr[15:0]}
                  + {3'd0, item.dst_addr[31:16]} + {3'd0, item.dst_addr[15:0]}
                  + {11'd0, item.proto_num}
                  + {3'd0, item.ip_total_len - IP_HEADER_BYTES};
        seed_sum  = fold(seed_wide);

        if (item.byte_valid == BV_ONE)
        begin
            word_masked = {item.data_word[15:8], 8'd0};
            nbytes      = 2'd1;
        end
        else
        begin
            word_masked = item.data_word;
            nbytes      = 2'd2;
        end

        // checksum word counts as zero, length word too when it gets refilled
        priority if (count_reg == CSUM_WORD_OFFSET)
            addend = 16'd0;
        else if (count_reg == LEN_WORD_OFFSET && cfg.fill_length)
            addend = 16'd0;
        else
            addend = word_masked;

        count_wide = {1'b0, count_reg} + {15'd0, nbytes};
        count_sat  = count_wide[16] ? ALL_ONES : count_wide[15:0];
        len_term   = cfg.fill_length ? count_sat : 16'd0;

        total_wide = {3'd0, sum_reg} + {3'd0, addend} + {3'd0, len_term};
        total_sum  = fold(total_wide);
        csum_inv   = ~total_sum;

        result.udp_length = len_term;
        if (!cfg.fill_checksum)
            result.udp_checksum = 16'd0;
        else if (csum_inv == 16'd0)
            result.udp_checksum = ALL_ONES;
        else
            result.udp_checksum = csum_inv;

        sum_next   = sum_reg;
        count_next = count_reg;
        if (fire)
        begin
            if (item.mode == MODE_START)
            begin
                sum_next   = seed_sum;
                count_next = 16'd0;
            end
            else if (item.last)
            begin
                sum_next   = 16'd0;
                count_next = 16'd0;
            end
            else
            begin
                sum_next   = fold({3'd0, sum_reg} + {3'd0, addend});
                count_next = count_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= 16'd0;
            count_reg <= 16'd0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/udp_length_checksum_insert_top.sv
// ----------------------------------------------------------------------------
// udp_length_checksum_insert_top
// fills the udp length and checksum fields from a streamed segment
// ----------------------------------------------------------------------------
// a start beat (mode 0) carries source, destination, protocol and the ip
// total length and seeds the pseudo-header sum; segment beats (mode 1)
// then stream one 16-bit word each. the beat with last set produces one
// result beat holding the counted length and the final checksum; no other
// beat produces a result.
// item and res are valid/ready channels. each accepted beat lands in an
// input register and is folded into the running sum when it fires from
// there; the result for the last word is registered in the result
// register, which drives res_valid and holds until res is taken.
// throughput is one beat per cycle while res is not stalled, bounded by the
// combinational sum-and-fold path between the input register and the result register.
// when res stalls, the result register holds; word beats keep flowing
// until a second last word has to wait behind it.
// the cfg port takes a write every cycle; fill_length and fill_checksum
// reset to 1. reset clears the sum, the byte count and both valid flags.
// ----------------------------------------------------------------------------
module udp_length_checksum_insert_top
    import udp_lci_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  in_item_t             item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output out_item_t            res,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    cfg_t      cfg;
    logic      stage_valid_reg, stage_valid_next;
    in_item_t  stage_reg,       stage_next;
    logic      res_valid_reg,   res_valid_next;
    out_item_t res_reg,         res_next;
    out_item_t core_result;
    logic      needs_out;
    logic      out_free;
    logic      stage_fire;

    udp_lci_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    udp_lci_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (stage_fire),
        .item   (stage_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_comb
    begin
        needs_out  = (stage_reg.mode == MODE_WORD) && stage_reg.last;
        out_free   = !res_valid_reg || res_ready;
        stage_fire = stage_valid_reg && (!needs_out || out_free);
        item_ready = !stage_valid_reg || stage_fire;

        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        if (item_valid && item_ready)
        begin
            stage_valid_next = 1'b1;
            stage_next       = item;
        end
        else if (stage_fire)
        begin
            stage_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (stage_fire && needs_out)
        begin
            res_valid_next = 1'b1;
            res_next       = core_result;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
        res_reg   <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
